@@ rtl/core/utf8vs_pkg.sv @@
// Shared codes and types for the UTF-8 checker and sanitiser.
package utf8vs_pkg;

	// Decoder states
	localparam logic [3:0] ST_BAD   = 4'd0;
	localparam logic [3:0] ST_START = 4'd1;
	localparam logic [3:0] ST_C1    = 4'd2;
	localparam logic [3:0] ST_C2    = 4'd3;
	localparam logic [3:0] ST_C3    = 4'd4;
	localparam logic [3:0] ST_E0    = 4'd5;
	localparam logic [3:0] ST_F0    = 4'd6;
	localparam logic [3:0] ST_F4    = 4'd7;
	localparam logic [3:0] ST_ED    = 4'd8;

	// Kinds of result group caused by one input byte
	localparam logic [1:0] GRP_PASS = 2'd0;	// one beat, the byte itself
	localparam logic [1:0] GRP_REPL = 2'd1;	// three beats, U+FFFD
	localparam logic [1:0] GRP_DROP = 2'd2;	// one empty beat closing the message

	// U+FFFD encoded
	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	typedef struct packed {
		logic [3:0] state;
		logic       in_bad_run;
		logic       seen_bad;
	} dec_regs_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       msg_end;
		logic       msg_valid;
	} grp_t;

	typedef struct packed {
		dec_regs_t regs;
		logic      emit;
		grp_t      grp;
	} dec_out_t;

endpackage

@@ rtl/core/utf8vs_in_if.sv @@
// Input channel: one raw byte per beat.
interface utf8vs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

@@ rtl/core/utf8vs_out_if.sv @@
// Output channel: one sanitised result per beat.
interface utf8vs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_present;
	logic       run_last;
	logic       msg_end;
	logic       msg_valid;

	modport source (output valid, output out_byte, output out_present, output run_last,
		output msg_end, output msg_valid, input ready);
	modport sink (input valid, input out_byte, input out_present, input run_last,
		input msg_end, input msg_valid, output ready);
endinterface

@@ rtl/core/utf8vs_decode.sv @@
// Next-state and result classification for one byte of the UTF-8 decoder.
module utf8vs_decode (
	input  logic                 [7:0] data,
	input  logic                       last,
	input  utf8vs_pkg::dec_regs_t      cur,
	output utf8vs_pkg::dec_out_t       res
);
	import utf8vs_pkg::*;

	function automatic logic [3:0] lead_state(input logic [7:0] c);
		logic [3:0] s;
		if (!c[7]) begin
			s = ST_START;
		end else if (c[7:5] == 3'b110) begin
			// C0 and C1 can only start overlong forms
			s = (c[7:1] == 7'b1100000) ? ST_BAD : ST_C1;
		end else if (c[7:4] == 4'hE) begin
			if (c == 8'hE0)      s = ST_E0;
			else if (c == 8'hED) s = ST_ED;
			else                 s = ST_C2;
		end else if (c[7:3] == 5'b11110) begin
			if (c == 8'hF0)       s = ST_F0;
			else if (c == 8'hF4)  s = ST_F4;
			else if (c >= 8'hF5)  s = ST_BAD;
			else                  s = ST_C3;
		end else begin
			s = ST_BAD;
		end
		return s;
	endfunction

	logic       cont;
	logic [3:0] nxt;
	logic       bad_run_n;
	logic       seen_bad_n;

	assign cont = (data[7:6] == 2'b10);

	always_comb begin
		unique case (cur.state)
			ST_C1:   nxt = cont ? ST_START : ST_BAD;
			ST_C2:   nxt = cont ? ST_C1 : ST_BAD;
			ST_C3:   nxt = cont ? ST_C2 : ST_BAD;
			ST_E0:   nxt = (cont && data[5]) ? ST_C1 : ST_BAD;
			ST_F0:   nxt = (cont && (data[5:4] != 2'b00)) ? ST_C2 : ST_BAD;
			ST_F4:   nxt = (cont && (data <= 8'h8F)) ? ST_C2 : ST_BAD;
			ST_ED:   nxt = (cont && !data[5]) ? ST_C1 : ST_BAD;
			default: nxt = lead_state(data);
		endcase
	end

	always_comb begin
		bad_run_n  = cur.in_bad_run;
		seen_bad_n = cur.seen_bad;
		res.emit   = 1'b0;
		res.grp.kind = GRP_PASS;
		res.grp.data = data;
		if (nxt != ST_BAD) begin
			bad_run_n = 1'b0;
			res.emit  = 1'b1;
		end else if (!cur.in_bad_run) begin
			// first byte of an invalid run
			bad_run_n    = 1'b1;
			seen_bad_n   = 1'b1;
			res.emit     = 1'b1;
			res.grp.kind = GRP_REPL;
		end else if (last) begin
			res.emit     = 1'b1;
			res.grp.kind = GRP_DROP;
		end
		res.grp.msg_end   = last;
		res.grp.msg_valid = last && !seen_bad_n && (nxt == ST_START);

		// message end returns everything to reset values
		if (last) begin
			res.regs.state      = ST_START;
			res.regs.in_bad_run = 1'b0;
			res.regs.seen_bad   = 1'b0;
		end else begin
			res.regs.state      = nxt;
			res.regs.in_bad_run = bad_run_n;
			res.regs.seen_bad   = seen_bad_n;
		end
	end

endmodule

@@ rtl/core/utf8_validate_sanitize.sv @@
// Top level of the streaming UTF-8 checker and sanitiser.
//
// Bytes enter on in_ch, one per beat, and leave sanitised on out_ch. Each accepted
// byte is held in a one-entry input register, decoded there by a nine-state UTF-8
// checker (overlong forms, surrogates, values above U+10FFFF and bad continuation
// bytes are rejected) and its result group is loaded into an output register. A
// good byte gives one beat carrying it; the first byte of an invalid run gives three
// beats EF BF BD; further bytes of that run give nothing, except that a dropped
// final byte gives one beat with out_present low. run_last marks the last beat of
// each input byte, msg_end the last beat of the message, and msg_valid (on that
// beat) reports that the whole message was well formed and ended complete. A
// truncated trailing sequence has already been passed through and leaves
// msg_valid low. Throughput is one byte per cycle while out_ch is ready; the
// first byte of each invalid run occupies the output register for its three
// beats, which is what limits the rate, and the input register absorbs one
// further byte during that time. There is no configuration and no start-up sweep.
module utf8_validate_sanitize (
	input  logic         clk,
	input  logic         arst_n,
	utf8vs_in_if.sink    in_ch,
	utf8vs_out_if.source out_ch
);
	import utf8vs_pkg::*;

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// decoder state
	dec_regs_t  dec_q;
	dec_out_t   dec_res;

	// output register stage: one result group, walked beat by beat
	logic       valid_s2;
	grp_t       grp_s2;
	logic [1:0] beat_q;

	logic       final_beat;
	logic       grp_done;
	logic       adv_s1;

	utf8vs_decode u_decode (
		.data (byte_s1),
		.last (last_s1),
		.cur  (dec_q),
		.res  (dec_res)
	);

	// last beat of the group in the output register
	assign final_beat = (grp_s2.kind != GRP_REPL) || (beat_q == 2'd2);
	assign grp_done   = valid_s2 && out_ch.ready && final_beat;
	// advance the input register into the output register once that is free
	assign adv_s1     = valid_s1 && (!valid_s2 || grp_done);
	assign in_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.in_last;
		end
	end

	// decoder state moves only when a byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q.state      <= ST_START;
			dec_q.in_bad_run <= 1'b0;
			dec_q.seen_bad   <= 1'b0;
		end else if (adv_s1) begin
			dec_q <= dec_res.regs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			beat_q   <= 2'd0;
		end else if (adv_s1) begin
			// a dropped byte inside a run loads nothing
			valid_s2 <= dec_res.emit;
			beat_q   <= 2'd0;
		end else if (grp_done) begin
			valid_s2 <= 1'b0;
			beat_q   <= 2'd0;
		end else if (valid_s2 && out_ch.ready) begin
			beat_q <= beat_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			grp_s2 <= dec_res.grp;
		end
	end

	// drive the output beat
	always_comb begin
		case (grp_s2.kind)
			GRP_PASS: begin
				out_ch.out_byte    = grp_s2.data;
				out_ch.out_present = 1'b1;
			end
			GRP_REPL: begin
				out_ch.out_present = 1'b1;
				case (beat_q)
					2'd0:    out_ch.out_byte = REPL_B0;
					2'd1:    out_ch.out_byte = REPL_B1;
					default: out_ch.out_byte = REPL_B2;
				endcase
			end
			default: begin
				out_ch.out_byte    = 8'h00;
				out_ch.out_present = 1'b0;
			end
		endcase
	end

	assign out_ch.valid     = valid_s2;
	assign out_ch.run_last  = final_beat;
	assign out_ch.msg_end   = final_beat && grp_s2.msg_end;
	assign out_ch.msg_valid = final_beat && grp_s2.msg_valid;

`ifndef SYNTH
	// beat counter only walks a replacement group
	a_beat_repl: assert property (@(posedge clk) disable iff (!arst_n)
		(beat_q != 2'd0) |-> (valid_s2 && grp_s2.kind == GRP_REPL))
		else $error("beat counter active outside a replacement group");

	// an open invalid run means the decoder sits in the bad state and has flagged it
	a_bad_run: assert property (@(posedge clk) disable iff (!arst_n)
		dec_q.in_bad_run |-> (dec_q.state == ST_BAD && dec_q.seen_bad))
		else $error("invalid run flag inconsistent with decoder state");

	// a well-formed message must end on a passed byte
	a_valid_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.msg_valid) |-> (out_ch.out_present && grp_s2.kind == GRP_PASS))
		else $error("message reported valid on a non-passed beat");
`endif

endmodule

@@ dv/utf8_validate_sanitize_test.sv @@
// Self-checking testbench for the streaming UTF-8 checker and sanitiser.
module utf8_validate_sanitize_test;
	timeunit 1ns;
	timeprecision 1ps;

	import utf8vs_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int RST_CYCLES = 8;
	localparam int QUIET_LIMIT = 2000;	// cycles with no beat on either side
	localparam int HOLD_CYCLES = 80;	// long receiver hold-off
	localparam int DRAIN_CYCLES = 10;	// settle time after the last expected beat

	// One result beat as seen on the output channel
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_present;
		logic       run_last;
		logic       msg_end;
		logic       msg_valid;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n;

	utf8vs_in_if  in_ch ();
	utf8vs_out_if out_ch ();

	utf8_validate_sanitize u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Predicted decoder state, mirrored byte by byte as input beats are accepted
	logic [3:0] dec_state = ST_START;
	logic       run_bad = 1'b0;		// inside an invalid run
	logic       msg_bad = 1'b0;		// sticky: message held an invalid byte

	beat_t      due_beats[$];		// beats still owed by the block, oldest first
	logic [7:0] msg_bytes[$];		// bytes of the message being sent

	int gap_pct = 14;			// idle chance per cycle on both sides
	bit hold_req = 1'b0;			// ask the receiver for a long hold-off
	int errors = 0;
	int bytes_sent = 0;
	int msgs_sent = 0;
	int beats_seen = 0;
	int repl_runs = 0;
	int dropped_ends = 0;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Advance the decoder by one byte
	function automatic logic [3:0] next_dec_state(input logic [7:0] c, input logic [3:0] s);
		logic cont;
		cont = (c[7:6] == 2'b10);
		case (s)
			ST_C1: return cont ? ST_START : ST_BAD;
			ST_C2: return cont ? ST_C1 : ST_BAD;
			ST_C3: return cont ? ST_C2 : ST_BAD;
			ST_E0: return (cont && c[5]) ? ST_C1 : ST_BAD;		// no overlong 3-byte
			ST_F0: return (cont && c[5:4] != 2'b00) ? ST_C2 : ST_BAD;	// no overlong 4-byte
			ST_F4: return (cont && c <= 8'h8F) ? ST_C2 : ST_BAD;	// stay below U+110000
			ST_ED: return (cont && !c[5]) ? ST_C1 : ST_BAD;		// no surrogates
			default: begin
				// Start, bad and any unused code all look for a lead byte
				if (!c[7])
					return ST_START;
				if (c[7:5] == 3'b110)
					return (c <= 8'hC1) ? ST_BAD : ST_C1;
				if (c[7:4] == 4'b1110) begin
					if (c == 8'hE0)
						return ST_E0;
					if (c == 8'hED)
						return ST_ED;
					return ST_C2;
				end
				if (c[7:3] == 5'b11110) begin
					if (c == 8'hF0)
						return ST_F0;
					if (c == 8'hF4)
						return ST_F4;
					if (c >= 8'hF5)
						return ST_BAD;
					return ST_C3;
				end
				return ST_BAD;
			end
		endcase
	endfunction

	function automatic beat_t make_beat(input logic [7:0] b, input logic present);
		beat_t r;
		r = '0;
		r.out_byte = b;
		r.out_present = present;
		return r;
	endfunction

	// Work out the beats that one accepted byte owes and queue them
	task automatic sanitise_byte(input logic [7:0] c, input logic last);
		beat_t grp[3];
		int    n;
		n = 0;
		dec_state = next_dec_state(c, dec_state);
		if (dec_state != ST_BAD) begin
			run_bad = 1'b0;
			grp[n++] = make_beat(c, 1'b1);
		end else if (!run_bad) begin
			// first byte of an invalid run: emit U+FFFD
			run_bad = 1'b1;
			msg_bad = 1'b1;
			grp[n++] = make_beat(REPL_B0, 1'b1);
			grp[n++] = make_beat(REPL_B1, 1'b1);
			grp[n++] = make_beat(REPL_B2, 1'b1);
			repl_runs++;
		end else if (last) begin
			// dropped final byte still has to close the message
			grp[n++] = make_beat(8'h00, 1'b0);
			dropped_ends++;
		end
		if (n > 0) begin
			grp[n-1].run_last = 1'b1;
			if (last) begin
				grp[n-1].msg_end = 1'b1;
				grp[n-1].msg_valid = !msg_bad && dec_state == ST_START;
			end
		end
		for (int i = 0; i < n; i++)
			due_beats.push_back(grp[i]);
		if (last) begin
			dec_state = ST_START;
			run_bad = 1'b0;
			msg_bad = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// Output side: random stalls, long hold-off on request, checking
	// ------------------------------------------------------------------

	task automatic check_beat(input beat_t got);
		beat_t want;
		if (due_beats.size() == 0) begin
			$error("unexpected beat: out_byte %02h present %0b", got.out_byte, got.out_present);
			errors++;
			return;
		end
		want = due_beats.pop_front();
		if (got.out_byte !== want.out_byte) begin
			$error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
			errors++;
		end
		if (got.out_present !== want.out_present) begin
			$error("out_present: expected %0b, got %0b", want.out_present, got.out_present);
			errors++;
		end
		if (got.run_last !== want.run_last) begin
			$error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
			errors++;
		end
		if (got.msg_end !== want.msg_end) begin
			$error("msg_end: expected %0b, got %0b", want.msg_end, got.msg_end);
			errors++;
		end
		if (got.msg_valid !== want.msg_valid) begin
			$error("msg_valid: expected %0b, got %0b", want.msg_valid, got.msg_valid);
			errors++;
		end
	endtask

	initial begin : rx_side
		int hold_left;
		beat_t got;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.out_byte = out_ch.out_byte;
				got.out_present = out_ch.out_present;
				got.run_last = out_ch.run_last;
				got.msg_end = out_ch.msg_end;
				got.msg_valid = out_ch.msg_valid;
				beats_seen++;
				check_beat(got);
			end
			// a hold-off request is counted out here, independent of the sender
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= gap_pct);
			end
		end
	end

	// Stop a hung run: count cycles with no beat accepted on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Offer one byte and hold it until accepted; valid is left high so the
	// next call can follow on without a bubble.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.in_last <= last;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sanitise_byte(b, last);
		bytes_sent++;
	endtask

	// Send msg_bytes as one message, last flag on the final byte
	task automatic send_msg_bytes();
		for (int i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
		msgs_sent++;
	endtask

	function automatic logic [7:0] rand_cont(input logic [7:0] lo, input logic [7:0] hi);
		return 8'($urandom_range(lo, hi));
	endfunction

	// Append one character to msg_bytes. Mostly well-formed code points of every
	// length, including the restricted second bytes; with noise_pct chance a raw
	// random byte instead, and with the same chance a multi-byte character cut short.
	task automatic add_char(input int noise_pct);
		logic [7:0] seq[4];
		int         len;
		int         form;
		if ($urandom_range(0, 99) < noise_pct) begin
			msg_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		form = $urandom_range(0, 4);
		case (form)
			0, 1: begin
				seq[0] = rand_cont(8'h00, 8'h7F);
				len = 1;
			end
			2: begin
				seq[0] = rand_cont(8'hC2, 8'hDF);
				seq[1] = rand_cont(8'h80, 8'hBF);
				len = 2;
			end
			3: begin
				seq[0] = rand_cont(8'hE0, 8'hEF);
				if (seq[0] == 8'hE0)
					seq[1] = rand_cont(8'hA0, 8'hBF);
				else if (seq[0] == 8'hED)
					seq[1] = rand_cont(8'h80, 8'h9F);
				else
					seq[1] = rand_cont(8'h80, 8'hBF);
				seq[2] = rand_cont(8'h80, 8'hBF);
				len = 3;
			end
			default: begin
				seq[0] = rand_cont(8'hF0, 8'hF4);
				if (seq[0] == 8'hF0)
					seq[1] = rand_cont(8'h90, 8'hBF);
				else if (seq[0] == 8'hF4)
					seq[1] = rand_cont(8'h80, 8'h8F);
				else
					seq[1] = rand_cont(8'h80, 8'hBF);
				seq[2] = rand_cont(8'h80, 8'hBF);
				seq[3] = rand_cont(8'h80, 8'hBF);
				len = 4;
			end
		endcase
		if (len > 1 && $urandom_range(0, 99) < noise_pct)
			len = $urandom_range(1, len - 1);
		for (int i = 0; i < len; i++)
			msg_bytes.push_back(seq[i]);
	endtask

	task automatic send_random_message(input int max_chars, input int noise_pct);
		msg_bytes.delete();
		repeat ($urandom_range(1, max_chars))
			add_char(noise_pct);
		send_msg_bytes();
	endtask

	// Lower valid after the last accepted beat and wait for every owed result
	task automatic drain_outputs();
		in_ch.valid <= 1'b0;
		wait (due_beats.size() == 0);
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-picked messages covering each decoder path and the odd endings
	task automatic test_directed();
		// largest legal code point, message valid
		msg_bytes = '{8'h7F, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_msg_bytes();
		// overlong lead starts a run; rest of the run dropped, final byte gives an empty beat
		msg_bytes = '{8'hC0, 8'h80, 8'hFF, 8'h80};
		send_msg_bytes();
		// each restricted second byte broken in turn, a lone F5, then a cut-off
		// three-byte character at the end
		msg_bytes = '{8'hE0, 8'h9F, 8'hED, 8'hA0, 8'hF0, 8'h8F, 8'hF4, 8'h90,
			8'h00, 8'hF5, 8'hE2, 8'h82};
		send_msg_bytes();
		// clean but truncated: valid must drop
		msg_bytes = '{8'hC2};
		send_msg_bytes();
		// lone continuation byte as the whole message
		msg_bytes = '{8'h80};
		send_msg_bytes();
	endtask

	// Bulk of the run: well-formed text with occasional noise and cut-offs
	task automatic test_random_text();
		int start;
		start = bytes_sent;
		while (bytes_sent - start < 170)
			send_random_message(10, 12);
	endtask

	// Back-to-back beats on both sides, heavy on replacement bursts
	task automatic test_steady_stream();
		int start;
		start = bytes_sent;
		gap_pct = 0;
		while (bytes_sent - start < 60)
			send_random_message(8, 35);
		gap_pct = 14;
	endtask

	// Receiver holds off for a long stretch while bytes keep coming, so the
	// block fills and stalls its input
	task automatic test_output_hold();
		int start;
		start = bytes_sent;
		hold_req = 1'b1;
		while (bytes_sent - start < 40)
			send_random_message(6, 40);
	endtask

	// Sender stops until every owed beat has been seen, then carries on
	task automatic test_sender_pause();
		int start;
		start = bytes_sent;
		while (bytes_sent - start < 20)
			send_random_message(6, 15);
		drain_outputs();
		start = bytes_sent;
		while (bytes_sent - start < 20)
			send_random_message(6, 15);
	endtask

	initial begin : main
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.in_last = 1'b0;
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_text();
		test_steady_stream();
		test_output_hold();
		test_sender_pause();

		drain_outputs();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d bytes in %0d messages, %0d result beats checked",
			bytes_sent, msgs_sent, beats_seen);
		$display("  with %0d replacement runs and %0d dropped message endings",
			repl_runs, dropped_ends);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/utf8vs_pkg.sv
rtl/core/utf8vs_in_if.sv
rtl/core/utf8vs_out_if.sv
rtl/core/utf8vs_decode.sv
rtl/core/utf8_validate_sanitize.sv
dv/utf8_validate_sanitize_test.sv
